// ===== src/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants, action codes and the sequencer state type.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int unsigned MOD_BITS_DEF = 31;
    localparam int unsigned EXP_BITS_DEF = 63;

    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    localparam logic ACT_POWER   = 1'b0;
    localparam logic ACT_INVERSE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_MUL,
        S_SQR,
        S_DONE
    } state_t;

endpackage

// ===== src/mexp_if.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready request and response channels of the exponentiation block.
// ----------------------------------------------------------------------------
interface mexp_req_if #(
    parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF,
    parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic                action;
    logic [MOD_BITS-1:0] base;
    logic [EXP_BITS-1:0] exponent;

    modport source (output valid, output action, output base, output exponent, input ready);
    modport sink (input valid, input action, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if #(
    parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

// ===== src/modular_exponentiation_top.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation, square and multiply
// Raises a base to an exponent, or to modulus minus two for the inverse
// action, modulo a configured modulus, with one bit-serial modular multiplier.
//
// The request channel carries action, base and exponent; the response channel
// carries one result item for every request item. The user must write the
// modulus register through cfg_we and cfg_wdata only while the block is idle;
// the block itself does not enforce this. One multiply runs through all
// MOD_BITS multiplier bits on the shared shift-and-add unit, which retires
// one multiplier bit per cycle with two compare-and-subtract steps.
// An item costs one multiply to reduce the base, then for each exponent bit
// below the top set bit one square, and for each set bit one multiply, with
// a decision state after each multiply or square and states to enter and
// leave. A modulus below two skips the multiplies and returns zero.
// The block takes a new item only when the previous one has left the
// sequencer. The result sits in an output register, so the sequencer can run
// the next item while the receiver stalls and waits only to hand over.
// Reset clears the sequencer, drops the output valid and loads the modulus
// with 1000000007.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
    parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF,
    parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [MOD_BITS-1:0] cfg_wdata,
    mexp_req_if.sink            request,
    mexp_rsp_if.source          response
);
    import mexp_pkg::*;

    localparam int unsigned EW = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS;
    localparam int unsigned CW = $clog2(MOD_BITS);
    localparam logic [MOD_BITS-1:0] MOD_RST = MOD_BITS'(MODULUS_RESET);
    localparam logic [CW-1:0] CNT_LAST = CW'(MOD_BITS - 1);

    state_t              state_reg, state_next;
    logic [MOD_BITS-1:0] modulus_reg;
    logic [EW-1:0]       exp_reg, exp_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] pw_reg, pw_next;
    logic [MOD_BITS-1:0] mx_reg, mx_next;
    logic [MOD_BITS-1:0] my_reg, my_next;
    logic [MOD_BITS-1:0] macc_reg, macc_next;
    logic [CW-1:0]       mcnt_reg, mcnt_next;
    logic [MOD_BITS-1:0] res_reg, res_next;
    logic                ovalid_reg, ovalid_next;

    logic                req_fire;
    logic                mod_small;
    logic                out_free;
    logic                mul_last;
    logic [MOD_BITS:0]   mod_ext;
    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS:0]   dbl_red;
    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS:0]   sum_red;
    logic [MOD_BITS-1:0] mul_res;

    assign request.ready   = (state_reg == S_IDLE);
    assign response.valid  = ovalid_reg;
    assign response.result = res_reg;

    assign req_fire  = request.valid && request.ready;
    assign mod_small = modulus_reg < MOD_BITS'(2);
    assign out_free  = !ovalid_reg || response.ready;
    assign mul_last  = (mcnt_reg == '0);

    // One step of the interleaved modular multiplier, multiplier bits MSB first.
    assign mod_ext = {1'b0, modulus_reg};
    assign dbl     = {macc_reg, 1'b0};
    assign dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    assign sum     = dbl_red + (mx_reg[MOD_BITS-1] ? {1'b0, my_reg} : '0);
    assign sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    assign mul_res = sum_red[MOD_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = mod_small ? S_DONE : S_REDUCE;
                end
            end
            S_REDUCE, S_MUL, S_SQR:
            begin
                if (mul_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (exp_reg[0])
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_SQR;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        exp_next    = exp_reg;
        acc_next    = acc_reg;
        pw_next     = pw_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        macc_next   = macc_reg;
        mcnt_next   = mcnt_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && response.ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (mod_small)
                    begin
                        acc_next = '0;
                    end
                    else
                    begin
                        acc_next  = MOD_BITS'(1);
                        exp_next  = (request.action == ACT_INVERSE)
                                  ? EW'(modulus_reg - MOD_BITS'(2))
                                  : EW'(request.exponent);
                        mx_next   = request.base;
                        my_next   = MOD_BITS'(1);
                        macc_next = '0;
                        mcnt_next = CNT_LAST;
                    end
                end
            end
            S_REDUCE, S_MUL, S_SQR:
            begin
                macc_next = mul_res;
                mx_next   = {mx_reg[MOD_BITS-2:0], 1'b0};
                mcnt_next = mcnt_reg - CW'(1);
                if (mul_last)
                begin
                    if (state_reg == S_MUL)
                    begin
                        acc_next    = mul_res;
                        exp_next[0] = 1'b0;
                    end
                    else if (state_reg == S_SQR)
                    begin
                        pw_next  = mul_res;
                        exp_next = exp_reg >> 1;
                    end
                    else
                    begin
                        pw_next = mul_res;
                    end
                end
            end
            S_CHECK:
            begin
                macc_next = '0;
                mcnt_next = CNT_LAST;
                mx_next   = exp_reg[0] ? acc_reg : pw_reg;
                my_next   = pw_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_next    = acc_reg;
                    ovalid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ovalid_reg  <= 1'b0;
            modulus_reg <= MOD_RST;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        pw_reg   <= pw_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        macc_reg <= macc_next;
        mcnt_reg <= mcnt_next;
        res_reg  <= res_next;
    end

    // The running product of the multiplier never leaves the residue range.
    a_macc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_SQR) |-> (macc_reg < modulus_reg))
        else $error("multiplier partial product not reduced");

    // Both operands are residues whenever the sequencer picks the next step.
    a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> (acc_reg < modulus_reg && pw_reg < modulus_reg))
        else $error("accumulator or power not reduced");

    // Each finished square consumes exactly one exponent bit.
    a_exp_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQR && mul_last) |=> (exp_reg == ($past(exp_reg) >> 1)))
        else $error("exponent not shifted after square");

    // A pending result is never overwritten while the receiver stalls.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !response.ready) |=> (res_reg == $past(res_reg)))
        else $error("pending result overwritten");

endmodule
